[sv/bchc_pkg.sv]
// bchc_pkg: shared types, phase and event codes, register map and reset
// values for the button click/hold classifier. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bchc_pkg;

  // Default width of the wrapping time base
  localparam int unsigned TimeWidthDef = 32;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned EventW = 2;
  localparam int unsigned ThrW   = 16;

  // Phase codes; 6 and 7 are unused and fall back to idle
  localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseW-1:0] PhDebounce = 3'd1;
  localparam logic [PhaseW-1:0] PhClicked  = 3'd2;
  localparam logic [PhaseW-1:0] PhHeld     = 3'd3;
  localparam logic [PhaseW-1:0] PhWaiting  = 3'd4;
  localparam logic [PhaseW-1:0] PhReleased = 3'd5;

  // Event codes
  localparam logic [EventW-1:0] EvNone  = 2'd0;
  localparam logic [EventW-1:0] EvClick = 2'd1;
  localparam logic [EventW-1:0] EvHold  = 2'd2;

  // Register map (word index = paddr[2])
  localparam logic RegDebounce = 1'b0;
  localparam logic RegHold     = 1'b1;

  localparam logic [ThrW-1:0] DebounceReset = 16'd100;
  localparam logic [ThrW-1:0] HoldReset     = 16'd750;

  typedef struct packed {
    logic [31:0] now_ticks;
    logic        button_pressed;
  } in_item_t;

  typedef struct packed {
    logic [EventW-1:0] button_event;
    logic              is_idle;
  } out_item_t;

  // Thresholds handed to the step logic
  typedef struct packed {
    logic [ThrW-1:0] debounce_ticks;
    logic [ThrW-1:0] hold_ticks;
  } cfg_t;

endpackage

`default_nettype wire

[sv/bchc_step.sv]
// bchc_step: one-poll update of the click/hold phase machine.
// Depends on bchc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bchc_step #(
  parameter int unsigned TimeWidth = bchc_pkg::TimeWidthDef
) (
  input  bchc_pkg::cfg_t                 cfg_i,
  input  logic [bchc_pkg::PhaseW-1:0]    phase_i,
  input  logic [TimeWidth-1:0]           stamp_i,
  input  bchc_pkg::in_item_t             item_i,
  output logic [bchc_pkg::PhaseW-1:0]    phase_o,
  output logic [TimeWidth-1:0]           stamp_o,
  output bchc_pkg::out_item_t            result_o
);

  logic [TimeWidth-1:0]  now_tw;
  logic [TimeWidth-1:0]  elapsed;
  logic [63:0]           elapsed_ext;
  logic                  deb_done;
  logic                  hold_done;
  logic                  pressed;
  logic [bchc_pkg::EventW-1:0] ev;

  assign pressed     = item_i.button_pressed;
  assign now_tw      = TimeWidth'(item_i.now_ticks);
  assign elapsed     = now_tw - stamp_i;  // wraps mod 2^TimeWidth
  assign elapsed_ext = 64'(elapsed);
  assign deb_done    = elapsed_ext >= 64'(cfg_i.debounce_ticks);
  assign hold_done   = elapsed_ext >= 64'(cfg_i.hold_ticks);

  always_comb begin
    phase_o = phase_i;
    stamp_o = stamp_i;
    ev      = bchc_pkg::EvNone;
    case (phase_i)
      bchc_pkg::PhIdle: begin
        if (pressed) begin
          stamp_o = now_tw;
          phase_o = bchc_pkg::PhDebounce;
        end
      end
      bchc_pkg::PhDebounce: begin
        if (deb_done) begin
          if (pressed) begin
            stamp_o = now_tw;
            phase_o = bchc_pkg::PhClicked;
          end else begin
            phase_o = bchc_pkg::PhIdle;
          end
        end
      end
      bchc_pkg::PhClicked: begin
        // hold test wins over release on the same poll
        if (hold_done) begin
          phase_o = bchc_pkg::PhHeld;
        end else if (!pressed) begin
          phase_o = bchc_pkg::PhReleased;
        end
      end
      bchc_pkg::PhHeld: begin
        ev      = bchc_pkg::EvHold;
        phase_o = bchc_pkg::PhWaiting;
      end
      bchc_pkg::PhWaiting: begin
        if (!pressed) begin
          phase_o = bchc_pkg::PhIdle;
        end
      end
      bchc_pkg::PhReleased: begin
        ev      = bchc_pkg::EvClick;
        phase_o = bchc_pkg::PhIdle;
      end
      default: begin
        phase_o = bchc_pkg::PhIdle;
      end
    endcase
  end

  assign result_o.button_event = ev;
  assign result_o.is_idle      = (phase_o == bchc_pkg::PhIdle) && !pressed;

endmodule

`default_nettype wire

[sv/button_click_hold_classifier.sv]
// button_click_hold_classifier: top level with input and result registers,
// phase/stamp state and APB-style config. Depends on bchc_pkg, bchc_step.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer is one poll of the button: the current free-running
// tick count and the pressed level. Every poll yields exactly one result
// transfer with a click/hold event code and an idle flag. A press in idle
// starts a debounce window of debounce_ticks; if still pressed at its end
// the press is confirmed and timed. Reaching hold_ticks gives a hold event
// on the following poll (then the block waits for release); releasing
// earlier gives a click on the following poll. Time differences wrap
// modulo 2^TimeWidth, and only the low TimeWidth bits of now_ticks count.
// Timing: one poll per clock sustained while the result register drains.
// A poll waits in the input register, where the phase update is a single
// subtract, two compares and the state decode; the result then moves to
// the output register when the poll advances, and result valid rises
// with that move. The input register takes a new poll in the same cycle
// the held one advances, and stalls only when the result register is
// full and not being taken.
// Registers: debounce_ticks at byte address 0, hold_ticks at 4 (16 bits,
// low half of pwdata). Write them only while no poll is in flight.
module button_click_hold_classifier #(
  parameter int unsigned TimeWidth = bchc_pkg::TimeWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // poll channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bchc_pkg::in_item_t   in_item_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bchc_pkg::out_item_t  out_item_o,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // config registers
  bchc_pkg::cfg_t cfg_q;
  logic           cfg_wr;

  // input stage
  logic               in_valid_q;
  bchc_pkg::in_item_t in_q;

  // result stage
  logic                out_valid_q;
  bchc_pkg::out_item_t out_q;

  // machine state
  logic [bchc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [TimeWidth-1:0]        stamp_q, stamp_d;
  bchc_pkg::out_item_t         result_d;

  logic advance;  // input stage moves into the result stage

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= bchc_pkg::DebounceReset;
      cfg_q.hold_ticks     <= bchc_pkg::HoldReset;
    end else if (cfg_wr) begin
      if (paddr[2] == bchc_pkg::RegDebounce) begin
        cfg_q.debounce_ticks <= pwdata[bchc_pkg::ThrW-1:0];
      end else begin
        cfg_q.hold_ticks <= pwdata[bchc_pkg::ThrW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bchc_pkg::RegHold) begin
      prdata = 32'(cfg_q.hold_ticks);
    end else begin
      prdata = 32'(cfg_q.debounce_ticks);
    end
  end

  // handshake: result register frees up as it is taken
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  bchc_step #(
    .TimeWidth (TimeWidth)
  ) u_step (
    .cfg_i    (cfg_q),
    .phase_i  (phase_q),
    .stamp_i  (stamp_q),
    .item_i   (in_q),
    .phase_o  (phase_d),
    .stamp_o  (stamp_d),
    .result_o (result_d)
  );

  // state commits only when the poll leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bchc_pkg::PhIdle;
      stamp_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
